@@ sv/svsr_pkg.sv @@
package svsr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_READY    = 2'd0,
    STAT_TIMEOUT  = 2'd1,
    STAT_FRAMING  = 2'd2,
    STAT_CHECKSUM = 2'd3
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_DATA   = 1'b1
  } kind_t;

  localparam logic [7:0]  HDR_BYTE      = 8'hFF;
  localparam logic [7:0]  SUM_OK        = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam int          FRAME_EXTRA   = 6;
  localparam int          DATA_POS      = 5;

endpackage

@@ sv/svsr_if.sv @@
interface svsr_in_if;
  logic                 valid;
  logic                 ready;
  svsr_pkg::cmd_t       command;
  logic [7:0]           byte_value;
  logic [4:0]           expected_len;

  modport source (output valid, output command, output byte_value, output expected_len,
                  input ready);
  modport sink   (input valid, input command, input byte_value, input expected_len,
                  output ready);
endinterface

interface svsr_out_if;
  logic                 valid;
  logic                 ready;
  svsr_pkg::kind_t      kind;
  svsr_pkg::status_t    status;
  logic [7:0]           servo_id;
  logic [7:0]           servo_error;
  logic [7:0]           data_byte;
  logic                 last;

  modport source (output valid, output kind, output status, output servo_id,
                  output servo_error, output data_byte, output last, input ready);
  modport sink   (input valid, input kind, input status, input servo_id,
                  input servo_error, input data_byte, input last, output ready);
endinterface

@@ sv/svsr_data_buf.sv @@
module svsr_data_buf #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/servo_status_packet_receiver.sv @@
// A status result is loaded into the output register by the transaction that completes
// a packet or times it out.
// Throughput: one input transaction per cycle while the output is free; a good packet
// with N data bytes then holds the input while its N bytes drain one per free cycle.
// Reset (rst_n, synchronous, active low): idle, no result pending, timeout_r = 200.
module servo_status_packet_receiver #(
  parameter int MAX_DATA = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  svsr_in_if.sink     in_ch,
  svsr_out_if.source  out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import svsr_pkg::*;

  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int LW = $clog2(MAX_DATA + 1);
  localparam int CW = $clog2(MAX_DATA + FRAME_EXTRA + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RECV  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        st_r, st_nxt;
  logic [15:0]   timeout_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] want_r, want_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          hok_r, hok_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    err_r, err_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [7:0]    out_id_r, out_id_nxt;
  logic [7:0]    out_err_r, out_err_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          slot_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;
  logic [CW-1:0] pos;
  logic [CW-1:0] dpos;
  status_t       chk;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r != ST_DRAIN) && slot_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign pos = count_r;
  assign dpos = pos - CW'(DATA_POS);

  svsr_data_buf #(
    .DEPTH (MAX_DATA),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.byte_value),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    st_nxt         = st_r;
    count_nxt      = count_r;
    want_nxt       = want_r;
    sum_nxt        = sum_r;
    hok_nxt        = hok_r;
    len_nxt        = len_r;
    id_nxt         = id_r;
    err_nxt        = err_r;
    tick_nxt       = tick_r;
    idx_nxt        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(dpos);
    chk            = STAT_READY;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_err_nxt    = out_err_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    if (accept) begin
      case (in_ch.command)
        CMD_START: begin
          st_nxt    = ST_RECV;
          count_nxt = '0;
          if (32'(in_ch.expected_len) > MAX_DATA) begin
            want_nxt = LW'(MAX_DATA);
          end else begin
            want_nxt = LW'(in_ch.expected_len);
          end
          sum_nxt  = '0;
          hok_nxt  = 1'b1;
          len_nxt  = '0;
          id_nxt   = '0;
          err_nxt  = '0;
          tick_nxt = '0;
        end
        CMD_TICK: begin
          if (st_r == ST_RECV) begin
            if (tick_r != 16'hFFFF) begin
              tick_nxt = tick_r + 16'd1;
            end
            if (tick_nxt >= timeout_r) begin
              st_nxt         = ST_IDLE;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_STATUS;
              out_status_nxt = STAT_TIMEOUT;
              out_id_nxt     = '0;
              out_err_nxt    = '0;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
            end
          end
        end
        CMD_BYTE: begin
          if (st_r == ST_RECV) begin
            if (pos < CW'(2)) begin
              if (in_ch.byte_value != HDR_BYTE) begin
                hok_nxt = 1'b0;
              end
            end else begin
              sum_nxt = sum_r + in_ch.byte_value;
              if (pos == CW'(2)) begin
                id_nxt = in_ch.byte_value;
              end else if (pos == CW'(3)) begin
                len_nxt = in_ch.byte_value;
              end else if (pos == CW'(4)) begin
                err_nxt = in_ch.byte_value;
              end else if (dpos < CW'(want_r)) begin
                wr_en = 1'b1;
              end
            end
            count_nxt = pos + CW'(1);
            if (count_nxt == CW'(want_r) + CW'(FRAME_EXTRA)) begin
              st_nxt = ST_IDLE;
              if (!hok_r || ({1'b0, len_r} != 9'(want_r) + 9'd2)) begin
                chk = STAT_FRAMING;
              end else if (sum_nxt != SUM_OK) begin
                chk = STAT_CHECKSUM;
              end
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_STATUS;
              out_status_nxt = chk;
              out_id_nxt     = id_r;
              out_err_nxt    = err_r;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (chk == STAT_READY && want_r != '0) begin
                out_last_nxt = 1'b0;
                st_nxt       = ST_DRAIN;
                idx_nxt      = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (st_r == ST_DRAIN && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_DATA;
      out_status_nxt = STAT_READY;
      out_id_nxt     = '0;
      out_err_nxt    = '0;
      out_data_nxt   = rd_data;
      out_last_nxt   = (LW'(idx_r) + LW'(1)) == want_r;
      idx_nxt        = AW'(LW'(idx_r) + LW'(1));
      if (out_last_nxt) begin
        st_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      count_r     <= '0;
      want_r      <= '0;
      sum_r       <= '0;
      hok_r       <= 1'b1;
      len_r       <= '0;
      id_r        <= '0;
      err_r       <= '0;
      tick_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      want_r      <= want_nxt;
      sum_r       <= sum_nxt;
      hok_r       <= hok_nxt;
      len_r       <= len_nxt;
      id_r        <= id_nxt;
      err_r       <= err_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_err_r    <= out_err_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.servo_id    = out_id_r;
  assign out_ch.servo_error = out_err_r;
  assign out_ch.data_byte   = out_data_r;
  assign out_ch.last        = out_last_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import svsr_pkg::*;

  localparam int MAX_DATA = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 25;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    cmd_t       command;
    logic [7:0] byte_value;
    logic [4:0] expected_len;
  } bus_item_t;

  typedef struct {
    kind_t      kind;
    status_t    status;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [7:0] data_byte;
    logic       last;
  } status_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  svsr_in_if  in_ch ();
  svsr_out_if out_ch ();

  servo_status_packet_receiver #(.MAX_DATA(MAX_DATA)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bus_item_t      rx_stream[$];
  status_report_t reports_due[$];
  bus_item_t      on_wire;
  status_report_t due_rep;

  int gap_pct;
  int stall_pct;
  int failures;
  bit hold_go;
  bit hold_off;

  // receiver state mirror
  logic [15:0] timeout_limit_q;
  bit          armed;
  int          got_count;
  int          data_want;
  logic [7:0]  sum_acc;
  bit          hdr_good;
  logic [7:0]  len_seen;
  logic [7:0]  id_seen;
  logic [7:0]  err_seen;
  logic [7:0]  payload[MAX_DATA];
  logic [15:0] ticks_seen;

  always #2 clk = ~clk;

  function automatic void decode_bus_item(bus_item_t it);
    status_t verdict;
    case (it.command)
      CMD_START: begin
        armed = 1'b1;
        got_count = 0;
        data_want = (it.expected_len > MAX_DATA) ? MAX_DATA : int'(it.expected_len);
        sum_acc = 8'h00;
        hdr_good = 1'b1;
        len_seen = 8'h00;
        id_seen = 8'h00;
        err_seen = 8'h00;
        ticks_seen = 16'h0000;
      end
      CMD_TICK: begin
        if (armed) begin
          if (ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
          if (ticks_seen >= timeout_limit_q) begin
            armed = 1'b0;
            reports_due.push_back('{KIND_STATUS, STAT_TIMEOUT, 8'h00, 8'h00, 8'h00, 1'b1});
          end
        end
      end
      CMD_BYTE: begin
        if (armed) begin
          if (got_count < 2) begin
            if (it.byte_value != HDR_BYTE) hdr_good = 1'b0;
          end else begin
            sum_acc = sum_acc + it.byte_value;
            if (got_count == 2) id_seen = it.byte_value;
            else if (got_count == 3) len_seen = it.byte_value;
            else if (got_count == 4) err_seen = it.byte_value;
            else if (got_count - DATA_POS < data_want) payload[got_count - DATA_POS] = it.byte_value;
          end
          got_count++;
          if (got_count >= data_want + FRAME_EXTRA) begin
            armed = 1'b0;
            if (!hdr_good || int'(len_seen) != data_want + 2) verdict = STAT_FRAMING;
            else if (sum_acc != SUM_OK) verdict = STAT_CHECKSUM;
            else verdict = STAT_READY;
            reports_due.push_back('{KIND_STATUS, verdict, id_seen, err_seen, 8'h00,
                                    (verdict != STAT_READY) || (data_want == 0)});
            if (verdict == STAT_READY) begin
              for (int i = 0; i < data_want; i++)
                reports_due.push_back('{KIND_DATA, STAT_READY, 8'h00, 8'h00, payload[i],
                                        i + 1 == data_want});
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_bus_item(on_wire);
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_wire = rx_stream.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= on_wire.command;
          in_ch.byte_value <= on_wire.byte_value;
          in_ch.expected_len <= on_wire.expected_len;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected transaction: kind %0d status %0d data %0d",
                 out_ch.kind, out_ch.status, out_ch.data_byte);
          failures++;
        end else begin
          due_rep = reports_due.pop_front();
          check_field("kind", due_rep.kind, out_ch.kind);
          check_field("status", due_rep.status, out_ch.status);
          check_field("servo_id", due_rep.servo_id, out_ch.servo_id);
          check_field("servo_error", due_rep.servo_error, out_ch.servo_error);
          check_field("data_byte", due_rep.data_byte, out_ch.data_byte);
          check_field("last", due_rep.last, out_ch.last);
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(negedge clk) hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_item(cmd_t cmd, logic [7:0] b, logic [4:0] len);
    rx_stream.push_back('{cmd, b, len});
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    timeout_limit_q = ticks;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (rx_stream.size() != 0 || in_ch.valid || reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random_packet(input int tick_pct, inout int counted);
    int req;
    int n;
    int flaw;
    int stop_at;
    int r;
    logic [7:0] frame[$];
    logic [7:0] sum;
    r = $urandom_range(99);
    if (r < 60) req = $urandom_range(4);
    else if (r < 85) req = $urandom_range(15, 5);
    else if (r < 93) req = MAX_DATA;
    else req = $urandom_range(31, MAX_DATA + 1);
    n = (req > MAX_DATA) ? MAX_DATA : req;
    frame.push_back(HDR_BYTE);
    frame.push_back(HDR_BYTE);
    frame.push_back(8'($urandom));
    frame.push_back(8'(n + 2));
    frame.push_back(8'($urandom));
    for (int i = 0; i < n; i++) frame.push_back(8'($urandom));
    sum = 8'h00;
    for (int i = 2; i < frame.size(); i++) sum = sum + frame[i];
    frame.push_back(SUM_OK - sum);
    stop_at = frame.size();
    flaw = $urandom_range(99);
    if (flaw >= 94) stop_at = $urandom_range(frame.size() - 1);
    else if (flaw >= 88) frame[frame.size() - 1] ^= 8'($urandom_range(255, 1));
    else if (flaw >= 82) frame[3] ^= 8'($urandom_range(255, 1));
    else if (flaw >= 76) frame[$urandom_range(1)] = 8'($urandom_range(254));
    queue_item(CMD_START, 8'($urandom), 5'(req));
    counted++;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(99) < tick_pct) queue_item(CMD_TICK, 8'($urandom), 5'($urandom));
      queue_item(CMD_BYTE, frame[i], 5'($urandom));
      counted++;
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(2))
          0: queue_item(CMD_BYTE, 8'($urandom), 5'($urandom));
          1: queue_item(CMD_TICK, 8'($urandom), 5'($urandom));
          default: queue_item(cmd_t'(CMD_UNUSED), 8'($urandom), 5'($urandom));
        endcase
      end
    end
  endtask

  task automatic run_random_phase(int gap, int stall, logic [15:0] ticks, int tick_pct,
                                  bit squeeze);
    int counted;
    counted = 0;
    gap_pct = gap;
    stall_pct = stall;
    write_timeout(ticks);
    if (squeeze) hold_go = 1'b1;
    while (counted < RANDOM_ITEMS) queue_random_packet(tick_pct, counted);
    wait_quiet();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 16'h0000;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_START;
    in_ch.byte_value = 8'h00;
    in_ch.expected_len = 5'd0;
    out_ch.ready = 1'b0;
    gap_pct = 10;
    stall_pct = 50;
    failures = 0;
    hold_go = 1'b0;
    timeout_limit_q = TIMEOUT_RESET;
    armed = 1'b0;
    got_count = 0;
    data_want = 0;
    sum_acc = 8'h00;
    hdr_good = 1'b1;
    len_seen = 8'h00;
    id_seen = 8'h00;
    err_seen = 8'h00;
    ticks_seen = 16'h0000;
    foreach (payload[i]) payload[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle: tick, stray byte and unused command all drop
    queue_item(CMD_TICK, 8'h00, 5'd0);
    queue_item(CMD_BYTE, 8'h00, 5'd0);
    queue_item(cmd_t'(CMD_UNUSED), 8'hFF, 5'd31);
    // restart a packet in flight
    queue_item(CMD_START, 8'h00, 5'd3);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_START, 8'h00, 5'd0);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_BYTE, 8'hFF, 5'd0);
    queue_item(CMD_BYTE, 8'h02, 5'd0);
    queue_item(CMD_BYTE, 8'hFF, 5'd0);
    queue_item(CMD_BYTE, 8'hFF, 5'd0);
    queue_item(CMD_START, 8'hFF, 5'd1);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_BYTE, 8'h00, 5'd0);
    queue_item(CMD_BYTE, 8'h03, 5'd0);
    queue_item(CMD_BYTE, 8'h00, 5'd0);
    queue_item(CMD_BYTE, 8'hFF, 5'd0);
    queue_item(CMD_BYTE, 8'hFD, 5'd0);
    wait_quiet();

    // time out a maximum-length request
    write_timeout(16'd2);
    queue_item(CMD_START, 8'h00, 5'd16);
    queue_item(CMD_BYTE, HDR_BYTE, 5'd0);
    queue_item(CMD_TICK, 8'h00, 5'd0);
    queue_item(CMD_TICK, 8'h00, 5'd0);
    wait_quiet();

    run_random_phase(10, 50, 16'hFFFF, 8, 1'b0);
    run_random_phase(50, 10, 16'($urandom_range(10, 3)), 15, 1'b0);
    run_random_phase(0, 0, 16'd1, 4, 1'b1);

    if (failures == 0 && reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
